// ===== hw/rtl/rltrq_pkg.sv =====
package rltrq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int TASK_ID_BITS = 8;

  localparam int TIME_W  = 32;
  localparam int ID_W    = 8;
  localparam int DELAY_W = 16;
  localparam int TOKEN_W = 8;
  localparam int RATE_W  = 10;
  localparam int HOLD_W  = 10;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Elapsed time saturates at 2^20 ticks, so it needs 21 bits.
  localparam int ELAPSED_W = 21;
  localparam logic [ELAPSED_W-1:0] ELAPSED_CAP = ELAPSED_W'(1 << 20);

  // elapsed * rate stays below 2^30 for every register value.
  localparam int PROD_W = 30;

  // Division by 1000 as a multiplication by ceil(2^40 / 1000) and a shift.
  // The error term is small enough that the quotient is exact over PROD_W bits.
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 40;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(1099511628);
  localparam int WIDE_W = PROD_W + RECIP_W;
  localparam int GAIN_W = WIDE_W - RECIP_SHIFT;

  localparam logic [TOKEN_W-1:0] CAPACITY_RESET = TOKEN_W'(2);
  localparam logic [RATE_W-1:0]  RATE_RESET     = RATE_W'(2);
  localparam logic [HOLD_W-1:0]  RETRY_RESET    = HOLD_W'(100);

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_RATE     = 2'd1;
  localparam logic [1:0] REG_RETRY    = 2'd2;

  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_SCHEDULE = 1'b1;

  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_DROP    = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [ID_W-1:0]    task_id;
    logic [DELAY_W-1:0] delay;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] task_id_res;
    logic            kind;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic                    valid;
    logic [TIME_W-1:0]       due;
    logic [TASK_ID_BITS-1:0] task_id;
  } cell_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } chain_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_MUL,
    ST_DIV,
    ST_REFILL,
    ST_RELEASE
  } state_t;

endpackage

// ===== hw/rtl/rltrq_cell.sv =====
module rltrq_cell (
  input  logic                clk,
  input  logic                rst,
  input  rltrq_pkg::chain_cmd_t cmd,
  input  rltrq_pkg::cell_t    new_item,
  input  rltrq_pkg::cell_t    left,
  input  logic                left_ins,
  input  rltrq_pkg::cell_t    right,
  input  logic                right_ins,
  output logic                ins,
  output rltrq_pkg::cell_t    q
);

  logic                                valid;
  logic [rltrq_pkg::TIME_W-1:0]        due;
  logic [rltrq_pkg::TASK_ID_BITS-1:0]  task_id;
  logic [rltrq_pkg::TIME_W-1:0]        diff;
  logic                                later;
  rltrq_pkg::cell_t                    load;
  logic                                take;

  // The new item lands before this entry when every stored entry from here
  // to the tail is due strictly later than the new item.
  assign diff  = new_item.due - due;
  assign later = diff[rltrq_pkg::TIME_W-1];
  assign ins   = (!valid || later) && right_ins;

  always_comb begin
    take = 1'b0;
    load = right;
    if (cmd.pop) begin
      take = 1'b1;
      load = right;
    end else if (cmd.insert && ins) begin
      take = 1'b1;
      load = left_ins ? left : new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= load.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      due     <= load.due;
      task_id <= load.task_id;
    end
  end

  assign q = '{valid: valid, due: due, task_id: task_id};

endmodule

// ===== hw/rtl/rltrq_chain.sv =====
module rltrq_chain (
  input  logic                  clk,
  input  logic                  rst,
  input  rltrq_pkg::chain_cmd_t cmd,
  input  rltrq_pkg::cell_t      new_item,
  output rltrq_pkg::cell_t      head,
  output rltrq_pkg::cell_t      second,
  output logic                  full
);

  localparam int N = rltrq_pkg::QUEUE_DEPTH;

  rltrq_pkg::cell_t cells [N];
  logic             ins   [N+1];

  assign ins[N] = 1'b1;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rltrq_pkg::cell_t left;
    rltrq_pkg::cell_t right;
    logic             left_ins;

    if (i == 0) begin : g_first
      assign left     = '0;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left     = cells[i-1];
      assign left_ins = ins[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = cells[i+1];
    end

    rltrq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .new_item  (new_item),
      .left      (left),
      .left_ins  (left_ins),
      .right     (right),
      .right_ins (ins[i+1]),
      .ins       (ins[i]),
      .q         (cells[i])
    );
  end

  assign head   = cells[0];
  assign second = cells[1];
  assign full   = cells[N-1].valid;

endmodule

// ===== hw/rtl/rltrq_refill.sv =====
module rltrq_refill (
  input  logic                             clk,
  input  logic [rltrq_pkg::TIME_W-1:0]     cur_time,
  input  logic [rltrq_pkg::TIME_W-1:0]     refill_time,
  input  logic [rltrq_pkg::RATE_W-1:0]     rate,
  output logic [rltrq_pkg::GAIN_W-1:0]     gain
);

  logic [rltrq_pkg::TIME_W-1:0]    elapsed;
  logic [rltrq_pkg::ELAPSED_W-1:0] elapsed_sat;
  logic [rltrq_pkg::PROD_W-1:0]    prod;
  logic [rltrq_pkg::WIDE_W-1:0]    wide;

  assign elapsed     = cur_time - refill_time;
  assign elapsed_sat = (elapsed > rltrq_pkg::TIME_W'(rltrq_pkg::ELAPSED_CAP))
                       ? rltrq_pkg::ELAPSED_CAP
                       : elapsed[rltrq_pkg::ELAPSED_W-1:0];

  // Two registered steps: elapsed * rate, then the divide by 1000.
  assign wide = rltrq_pkg::WIDE_W'(prod) * rltrq_pkg::WIDE_W'(rltrq_pkg::RECIP);

  always_ff @(posedge clk) begin
    prod <= rltrq_pkg::PROD_W'(rltrq_pkg::PROD_W'(elapsed_sat)
                               * rltrq_pkg::PROD_W'(rate));
    gain <= wide[rltrq_pkg::RECIP_SHIFT +: rltrq_pkg::GAIN_W];
  end

endmodule

// ===== hw/rtl/rate_limited_timed_release_queue.sv =====
// Timed release queue with a token bucket. A schedule beat stores a task in a
// sorted row of QUEUE_DEPTH cells when accepted; on a full queue it is dropped
// and one result with kind set is returned from the drop state. A tick beat
// only advances time while release is held, otherwise it passes the multiply,
// divide and refill states (the refill multiply and the divide by 1000 run as
// a two-stage pipeline) and, if the head is due, the release state, where the
// cell row pops its head once per cycle while the output register is free, at
// most QUEUE_DEPTH tasks per tick. A due task left with no token starts a hold.
// The input is taken again as soon as the previous beat is done; a result may
// still wait in the output register. No clearing pass follows reset.
module rate_limited_timed_release_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  rltrq_pkg::in_item_t           item,
  output logic                          res_valid,
  input  logic                          res_stall,
  output rltrq_pkg::out_item_t          res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rltrq_pkg::ADDR_W-1:0]  paddr,
  input  logic [rltrq_pkg::DATA_W-1:0]  pwdata,
  output logic [rltrq_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  rltrq_pkg::state_t                 state, state_next;
  logic [rltrq_pkg::TIME_W-1:0]      cur_time, cur_time_next;
  logic [rltrq_pkg::TIME_W-1:0]      refill_time, refill_time_next;
  logic [rltrq_pkg::TOKEN_W-1:0]     token_count, token_count_next;
  logic [rltrq_pkg::HOLD_W-1:0]      retry_hold, retry_hold_next;
  logic [rltrq_pkg::TOKEN_W-1:0]     bucket_capacity, bucket_capacity_next;
  logic [rltrq_pkg::RATE_W-1:0]      refill_rate;
  logic [rltrq_pkg::HOLD_W-1:0]      retry_wait;
  logic [rltrq_pkg::ID_W-1:0]        drop_id, drop_id_next;
  rltrq_pkg::out_item_t              res_next;
  logic                              res_load;
  logic                              res_free;

  rltrq_pkg::chain_cmd_t             cmd;
  rltrq_pkg::cell_t                  new_item;
  rltrq_pkg::cell_t                  head;
  rltrq_pkg::cell_t                  second;
  logic                              full;
  logic [rltrq_pkg::GAIN_W-1:0]      gain;

  logic                              accept;
  logic                              cfg_write;
  logic [1:0]                        cfg_index;
  logic [rltrq_pkg::TASK_ID_BITS-1:0] id_kept;
  logic [rltrq_pkg::TIME_W-1:0]      head_diff;
  logic [rltrq_pkg::TIME_W-1:0]      second_diff;
  logic                              head_due;
  logic                              second_due;
  logic [rltrq_pkg::GAIN_W:0]        fill_sum;
  logic                              is_last;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[3:2];

  always_comb begin
    unique case (cfg_index)
      rltrq_pkg::REG_CAPACITY: prdata = rltrq_pkg::DATA_W'(bucket_capacity);
      rltrq_pkg::REG_RATE:     prdata = rltrq_pkg::DATA_W'(refill_rate);
      rltrq_pkg::REG_RETRY:    prdata = rltrq_pkg::DATA_W'(retry_wait);
      default:                 prdata = '0;
    endcase
  end

  assign item_stall = (state != rltrq_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign res_free   = !res_valid || !res_stall;

  assign id_kept  = rltrq_pkg::TASK_ID_BITS'(item.task_id);
  assign new_item = '{valid:   1'b1,
                      due:     cur_time + rltrq_pkg::TIME_W'(item.delay),
                      task_id: id_kept};

  // A task is due once current time is not strictly before its due time.
  assign head_diff   = cur_time - head.due;
  assign second_diff = cur_time - second.due;
  assign head_due    = head.valid && !head_diff[rltrq_pkg::TIME_W-1];
  assign second_due  = second.valid && !second_diff[rltrq_pkg::TIME_W-1];

  assign fill_sum = (rltrq_pkg::GAIN_W+1)'(token_count) + (rltrq_pkg::GAIN_W+1)'(gain);

  rltrq_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .new_item (new_item),
    .head     (head),
    .second   (second),
    .full     (full)
  );

  rltrq_refill u_refill (
    .clk         (clk),
    .cur_time    (cur_time),
    .refill_time (refill_time),
    .rate        (refill_rate),
    .gain        (gain)
  );

  always_comb begin
    state_next           = state;
    cur_time_next        = cur_time;
    refill_time_next     = refill_time;
    token_count_next     = token_count;
    retry_hold_next      = retry_hold;
    bucket_capacity_next = bucket_capacity;
    drop_id_next         = drop_id;
    cmd                  = '0;
    res_load             = 1'b0;
    res_next             = '0;
    is_last              = 1'b0;

    unique case (state)
      rltrq_pkg::ST_IDLE: begin
        if (accept) begin
          if (item.opcode == rltrq_pkg::OP_SCHEDULE) begin
            if (full) begin
              drop_id_next = rltrq_pkg::ID_W'(id_kept);
              state_next   = rltrq_pkg::ST_DROP;
            end else begin
              cmd.insert = 1'b1;
            end
          end else begin
            cur_time_next = cur_time + 1'b1;
            if (retry_hold != '0) begin
              retry_hold_next = retry_hold - 1'b1;
            end
            // Release resumes on the tick that brings the hold to zero.
            if (retry_hold == '0 || retry_hold == rltrq_pkg::HOLD_W'(1)) begin
              state_next = rltrq_pkg::ST_MUL;
            end
          end
        end
      end
      rltrq_pkg::ST_DROP: begin
        if (res_free) begin
          res_load   = 1'b1;
          res_next   = '{task_id_res: drop_id, kind: rltrq_pkg::KIND_DROP, last: 1'b1};
          state_next = rltrq_pkg::ST_IDLE;
        end
      end
      rltrq_pkg::ST_MUL: begin
        state_next = rltrq_pkg::ST_DIV;
      end
      rltrq_pkg::ST_DIV: begin
        state_next = rltrq_pkg::ST_REFILL;
      end
      rltrq_pkg::ST_REFILL: begin
        // Only the first refill of a tick can add tokens: once tokens are
        // added the refill time equals the current time.
        if (head_due) begin
          if (gain != '0) begin
            refill_time_next = cur_time;
            token_count_next = (fill_sum > (rltrq_pkg::GAIN_W+1)'(bucket_capacity))
                               ? bucket_capacity
                               : fill_sum[rltrq_pkg::TOKEN_W-1:0];
          end
          state_next = rltrq_pkg::ST_RELEASE;
        end else begin
          state_next = rltrq_pkg::ST_IDLE;
        end
      end
      rltrq_pkg::ST_RELEASE: begin
        if (token_count == '0) begin
          retry_hold_next = retry_wait;
          state_next      = rltrq_pkg::ST_IDLE;
        end else if (res_free) begin
          is_last          = (token_count == rltrq_pkg::TOKEN_W'(1)) || !second_due;
          res_load         = 1'b1;
          res_next         = '{task_id_res: rltrq_pkg::ID_W'(head.task_id),
                               kind:        rltrq_pkg::KIND_RELEASE,
                               last:        is_last};
          token_count_next = token_count - 1'b1;
          cmd.pop          = 1'b1;
          if (is_last) begin
            if (second_due) begin
              retry_hold_next = retry_wait;
            end
            state_next = rltrq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = rltrq_pkg::ST_IDLE;
      end
    endcase

    if (cfg_write && cfg_index == rltrq_pkg::REG_CAPACITY) begin
      bucket_capacity_next = pwdata[rltrq_pkg::TOKEN_W-1:0];
      token_count_next     = pwdata[rltrq_pkg::TOKEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= rltrq_pkg::ST_IDLE;
      cur_time        <= '0;
      refill_time     <= '0;
      token_count     <= rltrq_pkg::CAPACITY_RESET;
      retry_hold      <= '0;
      bucket_capacity <= rltrq_pkg::CAPACITY_RESET;
    end else begin
      state           <= state_next;
      cur_time        <= cur_time_next;
      refill_time     <= refill_time_next;
      token_count     <= token_count_next;
      retry_hold      <= retry_hold_next;
      bucket_capacity <= bucket_capacity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refill_rate <= rltrq_pkg::RATE_RESET;
      retry_wait  <= rltrq_pkg::RETRY_RESET;
    end else if (cfg_write) begin
      if (cfg_index == rltrq_pkg::REG_RATE) begin
        refill_rate <= pwdata[rltrq_pkg::RATE_W-1:0];
      end
      if (cfg_index == rltrq_pkg::REG_RETRY) begin
        retry_wait <= pwdata[rltrq_pkg::HOLD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    drop_id <= drop_id_next;
    if (res_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  a_tokens_capped: assert property (@(posedge clk) disable iff (rst)
    token_count <= bucket_capacity)
    else $error("token count above bucket capacity");

  a_release_has_head: assert property (@(posedge clk) disable iff (rst)
    state == rltrq_pkg::ST_RELEASE |-> head.valid)
    else $error("release state with an empty queue");

  a_full_drops: assert property (@(posedge clk) disable iff (rst)
    accept && item.opcode == rltrq_pkg::OP_SCHEDULE && full
    |=> state == rltrq_pkg::ST_DROP)
    else $error("schedule on a full queue was not dropped");

  a_drop_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == rltrq_pkg::KIND_DROP |-> res.last)
    else $error("drop result not marked last");

endmodule

// ===== tb/rltrq_release_checker.sv =====
`timescale 1ns / 1ps

module rltrq_release_checker
  import rltrq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_stall,
  input  in_item_t             item,
  input  logic                 res_valid,
  input  logic                 res_stall,
  input  out_item_t            res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output int                   mismatches,
  output int                   outstanding,
  output int                   results_seen,
  output int                   drops_seen
);

  localparam longint unsigned TICKS_PER_PERIOD = 1000;
  localparam longint unsigned ELAPSED_LIMIT    = 64'd1 << 20;

  // Shadow copy of the registers and of the queue state.
  logic [TOKEN_W-1:0]      capacity;
  logic [RATE_W-1:0]       rate;
  logic [HOLD_W-1:0]       retry_wait;
  logic [TIME_W-1:0]       now;
  logic [TIME_W-1:0]       refilled_at;
  logic [TOKEN_W-1:0]      tokens;
  logic [HOLD_W-1:0]       hold_left;
  logic [TIME_W-1:0]       slot_due  [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0] slot_task [QUEUE_DEPTH];
  int                      slot_count;

  out_item_t expected_results[$];

  // True when time a lies strictly after time b, allowing for wrap.
  function automatic logic due_after(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = b - a;
    return diff[TIME_W-1];
  endfunction

  function automatic void refill_bucket();
    logic [TIME_W-1:0] span;
    longint unsigned   elapsed;
    longint unsigned   gain;
    longint unsigned   sum;
    span    = now - refilled_at;
    elapsed = span;
    if (elapsed > ELAPSED_LIMIT) elapsed = ELAPSED_LIMIT;
    gain = (elapsed * longint'(rate)) / TICKS_PER_PERIOD;
    // The refill point only moves when at least one token was earned.
    if (gain > 0) begin
      sum = longint'(tokens) + gain;
      if (sum > longint'(capacity)) sum = longint'(capacity);
      tokens      = sum[TOKEN_W-1:0];
      refilled_at = now;
    end
  endfunction

  function automatic void predict_releases(in_item_t it);
    logic [TIME_W-1:0] due;
    out_item_t         r;
    out_item_t         held;
    int                pos;
    int                n;
    int                i;
    if (it.opcode == OP_SCHEDULE) begin
      if (slot_count >= QUEUE_DEPTH) begin
        r.task_id_res = it.task_id;
        r.kind        = KIND_DROP;
        r.last        = 1'b1;
        expected_results.push_back(r);
        return;
      end
      due = now + TIME_W'(it.delay);
      pos = slot_count;
      // Stable insert: behind every task that is due no later.
      while (pos > 0 && due_after(slot_due[pos-1], due)) begin
        slot_due[pos]  = slot_due[pos-1];
        slot_task[pos] = slot_task[pos-1];
        pos--;
      end
      slot_due[pos]  = due;
      slot_task[pos] = it.task_id[TASK_ID_BITS-1:0];
      slot_count++;
      return;
    end

    now = now + 1;
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      if (hold_left != 0) return;
    end
    n = 0;
    while (slot_count > 0 && n < QUEUE_DEPTH && !due_after(slot_due[0], now)) begin
      refill_bucket();
      if (tokens == 0) begin
        hold_left = retry_wait;
        break;
      end
      tokens = tokens - 1;
      // Each release is queued once the next one is known, so the final
      // one of this tick can carry the last flag.
      if (n > 0) expected_results.push_back(held);
      held.task_id_res = ID_W'(slot_task[0]);
      held.kind        = KIND_RELEASE;
      held.last        = 1'b0;
      n++;
      for (i = 1; i < slot_count; i++) begin
        slot_due[i-1]  = slot_due[i];
        slot_task[i-1] = slot_task[i];
      end
      slot_count--;
    end
    if (n > 0) begin
      held.last = 1'b1;
      expected_results.push_back(held);
    end
  endfunction

  function automatic void apply_register_write(logic [ADDR_W-1:0] addr,
                                               logic [DATA_W-1:0] value);
    case (addr[ADDR_W-1:2])
      REG_CAPACITY: begin
        capacity = value[TOKEN_W-1:0];
        tokens   = value[TOKEN_W-1:0];
      end
      REG_RATE:  rate       = value[RATE_W-1:0];
      REG_RETRY: retry_wait = value[HOLD_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void compare_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result beat: task_id_res=%0d kind=%0d last=%0d",
             got.task_id_res, got.kind, got.last);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    if (got.task_id_res !== want.task_id_res) begin
      $error("task_id_res: expected %0d, got %0d", want.task_id_res, got.task_id_res);
      mismatches++;
    end
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatches++;
    end
  endfunction

  // Sampling on the falling edge sees exactly what the next rising edge sees.
  always @(negedge clk) begin
    if (rst) begin
      capacity     = CAPACITY_RESET;
      rate         = RATE_RESET;
      retry_wait   = RETRY_RESET;
      now          = '0;
      refilled_at  = '0;
      tokens       = CAPACITY_RESET;
      hold_left    = '0;
      slot_count   = 0;
      mismatches   = 0;
      results_seen = 0;
      drops_seen   = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) apply_register_write(paddr, pwdata);
      if (item_valid && !item_stall) predict_releases(item);
      if (res_valid && !res_stall) begin
        results_seen++;
        if (res.kind == KIND_DROP) drops_seen++;
        compare_result(res);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== tb/rate_limited_timed_release_queue_tb.sv =====
`timescale 1ns / 1ps

module rate_limited_timed_release_queue_tb;
  import rltrq_pkg::*;

  localparam int CYCLE_LIMIT      = 300000;
  localparam int LONG_HOLD_CYCLES = 400;
  // Covers a full tick that releases every queued task, plus the output register.
  localparam int DRAIN_CYCLES     = 40;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  in_item_t            item       = '0;
  logic                res_valid;
  logic                res_stall  = 1'b0;
  out_item_t           res;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [ADDR_W-1:0]   paddr      = '0;
  logic [DATA_W-1:0]   pwdata     = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int mismatches;
  int outstanding;
  int results_seen;
  int drops_seen;

  int items_sent     = 0;
  int settings_used  = 1;
  int burst_left     = 0;
  int hold_requests  = 0;
  int holds_served   = 0;

  always #6 clk = ~clk;

  rate_limited_timed_release_queue dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  rltrq_release_checker watch (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res          (res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .drops_seen   (drops_seen)
  );

  function automatic in_item_t make_item(logic op, logic [ID_W-1:0] id,
                                         logic [DELAY_W-1:0] dly);
    in_item_t it;
    it.opcode  = op;
    it.task_id = id;
    it.delay   = dly;
    return it;
  endfunction

  // Offers one beat and returns on the rising edge that accepts it.
  task automatic offer(input in_item_t it);
    int   gap;
    logic taken;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    item       <= it;
    item_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic random_items(input int count, input int schedule_pct);
    in_item_t it;
    int       k;
    for (k = 0; k < count; k++) begin
      it.opcode  = ($urandom_range(0, 99) < schedule_pct) ? OP_SCHEDULE : OP_TICK;
      it.task_id = ID_W'($urandom_range(0, 255));
      // Far-future delays are kept rare since such tasks sit in the queue for good.
      case ($urandom_range(0, 39))
        0:             it.delay = DELAY_W'($urandom_range(0, 65535));
        1, 2:          it.delay = '0;
        3, 4, 5, 6:    it.delay = DELAY_W'($urandom_range(0, 400));
        7, 8, 9, 10, 11, 12, 13, 14, 15, 16:
                       it.delay = DELAY_W'($urandom_range(0, 40));
        default:       it.delay = DELAY_W'($urandom_range(0, 6));
      endcase
      offer(it);
    end
  endtask

  task automatic write_register(input logic [1:0] index, input logic [DATA_W-1:0] value);
    logic ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    ready = 1'b0;
    while (!ready) begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // The bus goes idle before the next transfer.
    @(posedge clk);
  endtask

  // Lets every expected result come out and the block go quiet.
  task automatic drain();
    item_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(input int capacity, input int rate, input int wait_ticks);
    drain();
    write_register(REG_CAPACITY, DATA_W'(capacity));
    write_register(REG_RATE, DATA_W'(rate));
    write_register(REG_RETRY, DATA_W'(wait_ticks));
    settings_used++;
  endtask

  // Result side: changes its stall pattern every so often, and on request
  // holds off for a long stretch so that the queue backs up into the input.
  initial begin : receiver
    int mode;
    int span;
    int i;
    forever begin
      if (hold_requests > holds_served) begin
        res_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      for (i = 0; i < span && hold_requests == holds_served; i++) begin
        case (mode)
          0:       res_stall <= 1'b0;
          1:       res_stall <= ($urandom_range(0, 9) < 3);
          2:       res_stall <= ($urandom_range(0, 9) < 7);
          default: res_stall <= (i % 4 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL rate_limited_timed_release_queue");
    $finish;
  end

  initial begin : stimulus
    int k;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: two tokens, slow refill. Of three tasks due by time 1, two use
    // up the bucket, the third finds it empty and starts a hold.
    offer(make_item(OP_SCHEDULE, 8'hFF, 16'hFFFF));
    offer(make_item(OP_SCHEDULE, 8'h00, 16'h0000));
    offer(make_item(OP_SCHEDULE, 8'hA5, 16'h0000));
    offer(make_item(OP_SCHEDULE, 8'h5A, 16'h0001));
    offer(make_item(OP_TICK, 8'h00, 16'h0000));
    offer(make_item(OP_TICK, 8'hFF, 16'hFFFF));
    // Fill the queue with groups of equal due times, then overflow it.
    for (k = 0; k < 14; k++) begin
      offer(make_item(OP_SCHEDULE, ID_W'(8'h10 + k), DELAY_W'((k % 3) * 2)));
    end
    offer(make_item(OP_SCHEDULE, 8'h3C, 16'h0005));
    offer(make_item(OP_SCHEDULE, 8'hC3, 16'hAAAA));

    // Largest capacity and retry wait. The queue is still full and on hold, so
    // the first beats are drops while the result side holds off.
    reconfigure(255, 1000, 1023);
    hold_requests++;
    random_items(20, 100);
    random_items(120, 15);

    // Small settings: one token, almost no refill, retry on every tick.
    reconfigure(1, 1, 0);
    random_items(60, 45);

    // Short holds that expire often.
    reconfigure(3, 500, 3);
    random_items(70, 45);

    reconfigure(40, 1000, 5);
    random_items(100, 35);

    drain();
    $display("Sent %0d input beats over %0d register settings.", items_sent, settings_used);
    $display("Checked %0d result beats, %0d of them drops.", results_seen, drops_seen);
    if (mismatches == 0) begin
      $display("PASS rate_limited_timed_release_queue");
    end else begin
      $display("FAIL rate_limited_timed_release_queue");
    end
    $finish;
  end

endmodule
